/* hdl/nts_pkg.sv */
// Shared types, constants and lookup tables of the note tone synthesizer.
package nts_pkg;

  localparam int PHASE_BITS = 32;
  localparam int FADE_NOTES = 25;
  localparam int STEP_W     = 28;
  localparam int SEM_W      = 14;
  localparam int AMP_W      = 16;
  localparam int MAG_W      = 16;
  localparam int INCP_W     = SEM_W + STEP_W;
  localparam int INCW_W     = INCP_W + 8;

  localparam logic [AMP_W-1:0]  FULL_AMP   = 16'd32640;
  localparam logic [AMP_W-1:0]  FADE_STEP  =
    AMP_W'((32640 + FADE_NOTES / 2) / FADE_NOTES);
  localparam logic [STEP_W-1:0] STEP_RESET = 28'd24932236;
  localparam logic [30:0]       MID_LEVEL  = 31'd1069547520;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] LETTER_A = 3'd0;
  localparam logic [2:0] LETTER_B = 3'd1;

  localparam logic REG_STEP_PER_HZ = 1'b0;

  typedef struct packed {
    logic             note_start;
    logic             rest;
    logic             fade;
    logic [SEM_W-1:0] sem_q8;
    logic [3:0]       oct_shift;
  } nts_entry_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } nts_bk_stat_t;

  function automatic logic [SEM_W-1:0] semitone_q8(input logic [3:0] idx);
    logic [SEM_W-1:0] v;
    case (idx)
      4'd0:    v = 14'd7040;
      4'd1:    v = 14'd7459;
      4'd2:    v = 14'd7902;
      4'd3:    v = 14'd8372;
      4'd4:    v = 14'd8870;
      4'd5:    v = 14'd9397;
      4'd6:    v = 14'd9956;
      4'd7:    v = 14'd10548;
      4'd8:    v = 14'd11175;
      4'd9:    v = 14'd11840;
      4'd10:   v = 14'd12544;
      4'd11:   v = 14'd13290;
      default: v = 14'd7040;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] letter_add(input logic [2:0] letter);
    logic [3:0] v;
    case (letter)
      3'd1:    v = 4'd2;
      3'd2:    v = 4'd3;
      3'd3:    v = 4'd5;
      3'd4:    v = 4'd7;
      3'd5:    v = 4'd8;
      3'd6:    v = 4'd10;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] quarter_sine(input logic [4:0] idx);
    logic [MAG_W-1:0] v;
    case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3212;
      5'd2:    v = 16'd6393;
      5'd3:    v = 16'd9512;
      5'd4:    v = 16'd12540;
      5'd5:    v = 16'd15447;
      5'd6:    v = 16'd18205;
      5'd7:    v = 16'd20788;
      5'd8:    v = 16'd23170;
      5'd9:    v = 16'd25330;
      5'd10:   v = 16'd27246;
      5'd11:   v = 16'd28899;
      5'd12:   v = 16'd30274;
      5'd13:   v = 16'd31357;
      5'd14:   v = 16'd32138;
      5'd15:   v = 16'd32610;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

/* hdl/nts_front.sv */
// Front end: decodes a note beat into its semitone table entry and octave shift.
module nts_front
  import nts_pkg::*;
(
  input  logic       note_start,
  input  logic [2:0] letter,
  input  logic       sharp,
  input  logic [3:0] octave,
  input  logic       rest,
  input  logic       fade,
  output nts_entry_t entry
);

  logic        oct_ok;
  logic [6:0]  oct_term;
  logic [6:0]  a_term;
  logic [6:0]  semis;
  logic [14:0] div_prod;
  logic [3:0]  oct_q;
  logic [3:0]  semi_rem;

  always_comb begin
    oct_ok = (octave >= 4'd1) && (octave <= 4'd8);
    if (!oct_ok) begin
      oct_term = 7'd0;
    end else if (letter == LETTER_B) begin
      oct_term = 7'({3'b000, octave}) * 7'd12;
    end else begin
      oct_term = 7'({3'b000, 4'(octave - 4'd1)}) * 7'd12;
    end
    a_term = ((letter == LETTER_A) && (octave != 4'd0)) ? 7'd12 : 7'd0;
    semis  = 7'(sharp) + oct_term + 7'(letter_add(letter)) + a_term;
    // divide by 12: n * 171 / 2048 is exact for n below 128
    div_prod = 15'(semis) * 15'd171;
    oct_q    = div_prod[14:11];
    semi_rem = 4'(semis - 7'({3'b000, oct_q}) * 7'd12);

    entry.note_start = note_start;
    entry.rest       = rest;
    entry.fade       = fade;
    entry.sem_q8     = semitone_q8(semi_rem);
    entry.oct_shift  = oct_q;
  end

endmodule

/* hdl/nts_queue.sv */
// Short queue between the front end and the synthesis back end.
module nts_queue
  import nts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  nts_entry_t        wr_data,
  output logic              full,
  input  logic              rd_en,
  output nts_entry_t        rd_data,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  nts_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/nts_back.sv */
// Back end: increment and amplitude update, phase accumulator, sine interpolation, output.
module nts_back
  import nts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step_per_hz,
  input  logic              q_valid,
  input  nts_entry_t        q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_sample,
  output nts_bk_stat_t      stat
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] incr_r, incr_nxt;
  logic [AMP_W-1:0]      amp_r, amp_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s2_valid_r, s2_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  s1_load_r, s1_zero_r, s1_neg_r;
  logic [3:0]            s1_oct_r;
  logic [INCP_W-1:0]     s1_incp_r;
  logic [MAG_W-1:0]      s1_base_r;
  logic [27:0]           s1_interp_r;
  logic [31:0]           s2_prod_r;
  logic                  s2_neg_r;
  logic [7:0]            sample_r;

  logic                  out_take, s2_take, s2_adv, s1_move;
  logic [PHASE_BITS+31:0] phase_ext;
  logic [31:0]           p32;
  logic [30:0]           fold;
  logic [4:0]            seg;
  logic [MAG_W-1:0]      base, diff;
  logic [INCW_W-1:0]     inc_wide;
  logic [MAG_W-1:0]      mag;
  logic [32:0]           sum_pos;
  logic [30:0]           sum_neg;
  logic [7:0]            level;

  assign q_pop      = q_valid && !s1_valid_r;
  assign out_take   = !out_valid_r || out_ready;
  assign s2_adv     = s2_valid_r && out_take;
  assign s2_take    = !s2_valid_r || out_take;
  assign s1_move    = s1_valid_r && s2_take;
  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign stat.s1_valid = s1_valid_r;
  assign stat.s2_valid = s2_valid_r;

  // phase folded into the first quadrant, segment index and table values
  always_comb begin
    phase_ext = {phase_r, 32'b0};
    p32       = phase_ext[PHASE_BITS+31 -: 32];
    fold      = {1'b0, p32[29:0]};
    if (p32[30]) begin
      fold = 31'h4000_0000 - fold;
    end
    seg  = fold[30:26];
    base = quarter_sine(seg);
    diff = (seg[4]) ? '0 : MAG_W'(quarter_sine(5'(seg + 5'd1)) - base);
  end

  always_comb begin
    inc_wide = INCW_W'(s1_incp_r) << s1_oct_r;
    mag      = MAG_W'(s1_base_r + MAG_W'(s1_interp_r[27:16]));
    incr_nxt = incr_r;
    if (s1_move) begin
      if (s1_load_r) begin
        incr_nxt = inc_wide[47 -: PHASE_BITS];
      end else if (s1_zero_r) begin
        incr_nxt = '0;
      end
    end
    phase_nxt = s1_move ? PHASE_BITS'(phase_r + incr_nxt) : phase_r;

    amp_nxt = amp_r;
    if (q_pop && q_entry.note_start && q_entry.fade) begin
      amp_nxt = (amp_r > FADE_STEP) ? AMP_W'(amp_r - FADE_STEP) : '0;
    end

    s1_valid_nxt = q_pop ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s1_move ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    out_valid_nxt = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // output level: midpoint plus or minus the scaled sine, clamped
  always_comb begin
    sum_pos = 33'(MID_LEVEL) + 33'(s2_prod_r);
    sum_neg = MID_LEVEL - s2_prod_r[30:0];
    if (s2_neg_r) begin
      level = ({1'b0, s2_prod_r} >= 33'(MID_LEVEL)) ? 8'd0 : sum_neg[30:23];
    end else begin
      level = (sum_pos[32:23] > 10'd255) ? 8'd255 : sum_pos[30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      incr_r      <= '0;
      amp_r       <= FULL_AMP;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      incr_r      <= incr_nxt;
      amp_r       <= amp_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_load_r   <= q_entry.note_start && !q_entry.rest;
      s1_zero_r   <= q_entry.note_start && q_entry.rest;
      s1_oct_r    <= q_entry.oct_shift;
      s1_incp_r   <= INCP_W'(q_entry.sem_q8) * INCP_W'(step_per_hz);
      s1_base_r   <= base;
      s1_interp_r <= 28'(diff) * 28'(fold[25:10]);
      s1_neg_r    <= p32[31];
    end
    if (s1_move) begin
      s2_prod_r <= 32'(amp_r) * 32'(mag);
      s2_neg_r  <= s1_neg_r;
    end
    if (s2_adv) begin
      sample_r <= level;
    end
  end

endmodule

/* hdl/note_tone_synthesizer.sv */
// Note tone synthesizer top level: stream ports, APB register, front/back split.
// Sine tone generator driven by note beats. Each input beat is one sample tick and
// yields exactly one output sample. The front end decodes a beat in the cycle it
// arrives and parks it in a two-entry queue, so in_tready stays high while the queue
// has room. The back end takes a queued beat only once the previous one has left its
// increment stage: the new phase increment (semitone table value times step_per_hz,
// one multiply) must land in the phase accumulator before the next beat reads the
// phase. A beat passes through the queue, the increment stage, the product stage and
// the output register. step_per_hz sits at byte address 0 and should only be written
// while no beats are in flight.
module note_tone_synthesizer
  import nts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // letter[2:0], sharp[3], octave[7:4]
  input  logic [2:0]  in_tuser,    // note_start[0], rest[1], fade[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // sample[7:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [STEP_W-1:0] step_per_hz_r, step_per_hz_nxt;
  logic              cfg_wr;
  nts_entry_t        fe_entry;
  nts_entry_t        q_entry;
  logic              q_full, q_valid, q_pop, q_push;
  logic [QCNT_W-1:0] q_count;
  nts_bk_stat_t      bk_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_STEP_PER_HZ) ? 32'(step_per_hz_r) : 32'd0;

  always_comb begin
    step_per_hz_nxt = step_per_hz_r;
    if (cfg_wr && (cfg_paddr[2] == REG_STEP_PER_HZ)) begin
      step_per_hz_nxt = cfg_pwdata[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_per_hz_r <= STEP_RESET;
    end else begin
      step_per_hz_r <= step_per_hz_nxt;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  nts_front u_front (
    .note_start (in_tuser[0]),
    .letter     (in_tdata[2:0]),
    .sharp      (in_tdata[3]),
    .octave     (in_tdata[7:4]),
    .rest       (in_tuser[1]),
    .fade       (in_tuser[2]),
    .entry      (fe_entry)
  );

  nts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_push),
    .wr_data   (fe_entry),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_data   (q_entry),
    .not_empty (q_valid),
    .count     (q_count)
  );

  nts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_per_hz (step_per_hz_r),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_tdata),
    .stat        (bk_stat)
  );

  // a beat must see the phase left by the previous one
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end popped two beats in a row");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_stat.s1_valid)
    else $error("pop while increment stage busy");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("pop from empty queue");

endmodule
